// ===== sv/hcbd_pkg.sv =====
// Package for the chunked body decoder: decode phases, byte codes, result type, hex lookup.
`default_nettype none
package hcbd_pkg;

	typedef enum logic [2:0] {
		PH_BOUNDARY = 3'd0,
		PH_SIZE     = 3'd1,
		PH_EXT      = 3'd2,
		PH_DATA     = 3'd3,
		PH_DONE     = 3'd4,
		PH_ERROR    = 3'd5
	} phase_t;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	// Bits of one hex digit.
	localparam int unsigned HEX_BITS = 4;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] data_byte;
		logic       body_end;
		logic       framing_error;
	} result_t;

	typedef struct packed {
		logic                is_hex;
		logic [HEX_BITS-1:0] value;
	} hex_t;

	// Map an ASCII byte to its hexadecimal digit value, if it is one.
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.is_hex = 1'b0;
		r.value  = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.is_hex = 1'b1;
			r.value  = HEX_BITS'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.is_hex = 1'b1;
			r.value  = HEX_BITS'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.is_hex = 1'b1;
			r.value  = HEX_BITS'(c - 8'h37);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/hcbd_step.sv =====
// Next-state and result logic of the chunked body decoder for one byte.
`default_nettype none
module hcbd_step #(
	parameter int unsigned LINE_LIMIT = 4096,
	parameter int unsigned SIZE_BITS  = 32,
	parameter int unsigned LINE_W     = $clog2(LINE_LIMIT + 1)
) (
	input  wire logic [7:0]           in_byte,
	input  wire logic                 body_start,
	input  wire hcbd_pkg::phase_t     phase_cur,
	input  wire logic [SIZE_BITS-1:0] rem_cur,
	input  wire logic [LINE_W-1:0]    len_cur,
	output hcbd_pkg::phase_t          phase_nxt,
	output logic [SIZE_BITS-1:0]      rem_nxt,
	output logic [LINE_W-1:0]         len_nxt,
	output hcbd_pkg::result_t         result
);

	localparam logic [LINE_W-1:0] LIMIT = LINE_W'(LINE_LIMIT);
	localparam int unsigned       HB    = hcbd_pkg::HEX_BITS;

	hcbd_pkg::phase_t     ph;
	logic [SIZE_BITS-1:0] rem;
	logic [LINE_W-1:0]    len;
	logic [LINE_W-1:0]    len_inc;
	logic                 len_hit;
	logic [SIZE_BITS-1:0] rem_digit;
	logic [SIZE_BITS-1:0] rem_dec;
	hcbd_pkg::hex_t       hex;
	logic                 is_cr;
	logic                 is_lf;

	always_comb begin
		// body_start puts the decoder back at the boundary before this byte
		ph  = body_start ? hcbd_pkg::PH_BOUNDARY : phase_cur;
		rem = body_start ? '0 : rem_cur;
		len = body_start ? '0 : len_cur;

		hex   = hcbd_pkg::hex_decode(in_byte);
		is_cr = (in_byte == hcbd_pkg::CH_CR);
		is_lf = (in_byte == hcbd_pkg::CH_LF);

		len_inc = (len < LIMIT) ? len + LINE_W'(1) : len;
		len_hit = (len_inc >= LIMIT);

		// saturate once the top digit is occupied
		if (rem[SIZE_BITS-1 -: HB] != '0)
			rem_digit = '1;
		else
			rem_digit = {rem[SIZE_BITS-HB-1:0], hex.value};

		rem_dec = rem - SIZE_BITS'(1);

		phase_nxt = ph;
		rem_nxt   = rem;
		len_nxt   = len;
		result    = '0;

		case (ph)
			hcbd_pkg::PH_BOUNDARY: begin
				if (!is_cr && !is_lf) begin
					if (hex.is_hex) begin
						rem_nxt   = SIZE_BITS'(hex.value);
						len_nxt   = LINE_W'(1);
						phase_nxt = hcbd_pkg::PH_SIZE;
					end else begin
						rem_nxt   = '0;
						len_nxt   = '0;
						phase_nxt = hcbd_pkg::PH_ERROR;
					end
				end
			end
			hcbd_pkg::PH_SIZE: begin
				if (is_lf) begin
					phase_nxt = hcbd_pkg::PH_ERROR;
				end else begin
					len_nxt = len_inc;
					if (len_hit)
						phase_nxt = hcbd_pkg::PH_ERROR;
					else if (hex.is_hex)
						rem_nxt = rem_digit;
					else if (is_cr || in_byte == hcbd_pkg::CH_SEMI)
						phase_nxt = hcbd_pkg::PH_EXT;
					else
						phase_nxt = hcbd_pkg::PH_ERROR;
				end
			end
			hcbd_pkg::PH_EXT: begin
				if (is_lf) begin
					len_nxt = '0;
					if (rem == '0) begin
						result.body_end = 1'b1;
						phase_nxt       = hcbd_pkg::PH_DONE;
					end else begin
						phase_nxt = hcbd_pkg::PH_DATA;
					end
				end else begin
					len_nxt = len_inc;
					if (len_hit)
						phase_nxt = hcbd_pkg::PH_ERROR;
				end
			end
			hcbd_pkg::PH_DATA: begin
				if (rem != '0) begin
					result.data_valid = 1'b1;
					result.data_byte  = in_byte;
					rem_nxt           = rem_dec;
					if (rem_dec == '0)
						phase_nxt = hcbd_pkg::PH_BOUNDARY;
				end else begin
					phase_nxt = hcbd_pkg::PH_BOUNDARY;
				end
			end
			hcbd_pkg::PH_DONE: begin
				phase_nxt = hcbd_pkg::PH_DONE;
			end
			default: begin
				phase_nxt = hcbd_pkg::PH_ERROR;
			end
		endcase

		result.framing_error = (phase_nxt == hcbd_pkg::PH_ERROR);
	end

endmodule
`default_nettype wire

// ===== sv/http_chunked_body_decoder.sv =====
// Top level of the HTTP/1.1 chunked body decoder: handshake, stage registers, decode state.
//
// Input channel: in_valid / in_ready carry one body byte (in_byte) and the
// body_start flag, which returns the decoder to a chunk boundary with cleared
// size and line count before that byte is decoded.
// Output channel: out_valid / out_ready carry exactly one result item per
// input item: data_valid with data_byte (zero when not a payload byte),
// body_end on the LF closing the zero-size chunk line, and the sticky
// framing_error flag.
// Path: an accepted byte is held in the input register; the step logic then
// decodes it against the decode state and the result is loaded into the
// output register, which drives out_valid and the result outputs.
// Throughput: one item per cycle while the receiver takes results; the decode
// state is updated in the same cycle in which an item moves from the input
// register to the output register, so the next byte sees it at once.
// Reset (arst_n low): both stages empty, decoder at a chunk boundary with
// zero size and line count.
// Receiver stall: the output register holds its item; the input register
// keeps its byte and in_ready drops once both stages are full, so nothing
// is dropped or repeated. Up to two items are held during a stall.
`default_nettype none
module http_chunked_body_decoder #(
	parameter int unsigned LINE_LIMIT = 4096,
	parameter int unsigned SIZE_BITS  = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       body_start,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            data_valid,
	output logic [7:0]      data_byte,
	output logic            body_end,
	output logic            framing_error
);

	localparam int unsigned LINE_W = $clog2(LINE_LIMIT + 1);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// result stage
	logic              valid_s2;
	hcbd_pkg::result_t result_s2;

	// decode state
	hcbd_pkg::phase_t     phase_q;
	logic [SIZE_BITS-1:0] rem_q;
	logic [LINE_W-1:0]    len_q;

	hcbd_pkg::phase_t     phase_nxt;
	logic [SIZE_BITS-1:0] rem_nxt;
	logic [LINE_W-1:0]    len_nxt;
	hcbd_pkg::result_t    result_nxt;

	logic load_s2;
	logic load_s1;

	// Advance the result stage when it is empty or its item is taken;
	// advance the input stage when it is empty or its item moves on.
	assign load_s2  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || load_s2;
	assign load_s1  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1  <= in_byte;
			start_s1 <= body_start;
		end
	end

	hcbd_step #(
		.LINE_LIMIT (LINE_LIMIT),
		.SIZE_BITS  (SIZE_BITS),
		.LINE_W     (LINE_W)
	) u_step (
		.in_byte    (byte_s1),
		.body_start (start_s1),
		.phase_cur  (phase_q),
		.rem_cur    (rem_q),
		.len_cur    (len_q),
		.phase_nxt  (phase_nxt),
		.rem_nxt    (rem_nxt),
		.len_nxt    (len_nxt),
		.result     (result_nxt)
	);

	// Commit the decode state only when the byte actually moves to the result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hcbd_pkg::PH_BOUNDARY;
			rem_q   <= '0;
			len_q   <= '0;
		end else if (load_s2) begin
			phase_q <= phase_nxt;
			rem_q   <= rem_nxt;
			len_q   <= len_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			result_s2 <= result_nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign data_valid    = result_s2.data_valid;
	assign data_byte     = result_s2.data_byte;
	assign body_end      = result_s2.body_end;
	assign framing_error = result_s2.framing_error;

	// A payload byte never comes with an end mark or a framing error.
	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(result_s2.data_valid && (result_s2.body_end || result_s2.framing_error)))
		else $error("payload byte flagged as end or error");

	// While passing data, bytes are still owed.
	a_data_owed: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == hcbd_pkg::PH_DATA |-> rem_q != '0)
		else $error("data phase with zero bytes left");

	// A stalled result stays in the output register.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2 && $stable(result_s2))
		else $error("stalled result lost or changed");

	// Decode state moves only when an item moves to the result stage.
	a_state_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!load_s2 |=> $stable(phase_q) && $stable(rem_q) && $stable(len_q))
		else $error("decode state changed without an item");

endmodule
`default_nettype wire
